>>> sv/ftd_pkg.sv
// Shared types and codes for the float stream tail deframer.
`timescale 1ns / 1ps
package ftd_pkg;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_PRINT = 2'd2;
  localparam logic [1:0] KIND_SYNC  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SUM_ERR  = 3'd1;
  localparam logic [2:0] ST_LEN_CHG  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;
  localparam logic [2:0] ST_MISALIGN = 3'd5;
  localparam logic [2:0] ST_LOCKED   = 3'd6;
  localparam logic [2:0] ST_TAIL     = 3'd7;

  localparam logic [1:0] FT_PLAIN = 2'd0;
  localparam logic [1:0] FT_ALL   = 2'd1;
  localparam logic [1:0] FT_DUMP  = 2'd2;

  localparam logic [1:0] DA_NEW      = 2'd0;
  localparam logic [1:0] DA_CONTINUE = 2'd1;
  localparam logic [1:0] DA_END_APP  = 2'd2;
  localparam logic [1:0] DA_END_SOLO = 2'd3;

  localparam logic [1:0] SYNC_SEARCH  = 2'd0;
  localparam logic [1:0] SYNC_CONFIRM = 2'd1;
  localparam logic [1:0] SYNC_LOCKED  = 2'd2;

  localparam logic [15:0] SLACK_RESET  = 16'd1100;
  localparam logic [23:0] WINDOW_RESET = 24'hAAAAAA;
  localparam logic [23:0] WINDOW_TAIL  = 24'h800000;
  localparam logic [7:0]  TAIL_TOP     = 8'h7F;
  localparam logic [15:0] HI_PLAIN     = 16'h7F80;
  localparam logic [15:0] HI_ALL       = 16'h7F81;
  localparam logic [15:0] HI_DUMP      = 16'h7F82;
  localparam logic [15:0] HI_PRINT     = 16'h7F83;
  localparam logic [31:0] EXP_MASK     = 32'h7F800000;
  localparam logic [31:0] HALF_BITS    = 32'h3F000000;
  localparam logic [31:0] ONE_HALF_BITS = 32'h3FC00000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] data_word;
    logic [1:0]  frame_type;
    logic [2:0]  status;
    logic [15:0] word_count;
    logic [1:0]  dump_action;
    logic [7:0]  text_char;
    logic        last;
    logic        locked;
    logic [31:0] ok_frames;
    logic [31:0] err_frames;
  } result_t;

  // Classified byte handed from the front to the back.
  typedef struct packed {
    logic [1:0] nres;
    result_t    r0;
    result_t    r1;
  } job_t;

endpackage

>>> sv/ftd_if.sv
// Valid/ready stream interfaces for the deframer channels.
`timescale 1ns / 1ps
interface ftd_in_if import ftd_pkg::*; (input logic clk);
  logic       valid;
  logic       ready;
  logic       link_open;
  logic [7:0] rx_byte;
  modport source(output valid, link_open, rx_byte, input ready);
  modport sink(input valid, link_open, rx_byte, output ready);
endinterface

interface ftd_out_if import ftd_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] data_word;
  logic [1:0]  frame_type;
  logic [2:0]  status;
  logic [15:0] word_count;
  logic [1:0]  dump_action;
  logic [7:0]  text_char;
  logic        last;
  logic        locked;
  logic [31:0] ok_frames;
  logic [31:0] err_frames;
  modport source(output valid, kind, data_word, frame_type, status, word_count, dump_action,
                 text_char, last, locked, ok_frames, err_frames, input ready);
  modport sink(input valid, kind, data_word, frame_type, status, word_count, dump_action,
               text_char, last, locked, ok_frames, err_frames, output ready);
endinterface

interface ftd_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> sv/ftd_front.sv
// Front end: tracks sync and frame state per byte and classifies results.
`timescale 1ns / 1ps
module ftd_front import ftd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_link_open,
  input  logic [7:0]  in_rx_byte,
  input  logic [15:0] slack,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_ready
);

  logic [1:0]  sync_r, sync_nxt;
  logic [23:0] win_r, win_nxt;
  logic [1:0]  conf_r, conf_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [15:0] fw_r, fw_nxt;
  logic [15:0] len_r, len_nxt;
  logic        known_r, known_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] sbl_r, sbl_nxt;
  logic [31:0] ldw_r, ldw_nxt;
  logic [1:0]  pdk_r, pdk_nxt;
  logic [31:0] okc_r, okc_nxt;
  logic [31:0] erc_r, erc_nxt;

  logic        fire, match;
  logic [31:0] w;
  logic [15:0] hi, lo, sum_a, dsum;
  logic [16:0] limit, fw_test;
  logic [31:0] lv;
  logic        st_bit;
  result_t     blank, r0, r1;
  logic [1:0]  n;

  assign in_ready = job_ready;
  assign fire = in_valid && in_ready;
  assign match = (win_r == WINDOW_TAIL) && (in_rx_byte == TAIL_TOP);
  assign w = {in_rx_byte, asm_r};
  assign hi = w[31:16];
  assign lo = w[15:0];

  always_comb begin
    sync_nxt = sync_r; win_nxt = win_r; conf_nxt = conf_r; phase_nxt = phase_r;
    asm_nxt = asm_r; fw_nxt = fw_r; len_nxt = len_r; known_nxt = known_r;
    sum_nxt = sum_r; sbl_nxt = sbl_r; ldw_nxt = ldw_r; pdk_nxt = pdk_r;
    okc_nxt = okc_r; erc_nxt = erc_r;
    blank = '0;
    r0 = '0; r1 = '0; n = 2'd0;
    limit = {1'b0, len_r} + {1'b0, slack};
    fw_test = '0; sum_a = '0; dsum = '0; lv = '0; st_bit = 1'b0;
    if (!in_link_open) begin
      sync_nxt = SYNC_SEARCH; conf_nxt = '0; phase_nxt = '0;
    end else if (sync_r == SYNC_LOCKED) begin
      if (phase_r != 2'd3) begin
        unique case (phase_r)
          2'd0: asm_nxt = {16'd0, in_rx_byte};
          2'd1: asm_nxt = {asm_r[23:16], in_rx_byte, asm_r[7:0]};
          default: asm_nxt = {in_rx_byte, asm_r[15:0]};
        endcase
        phase_nxt = phase_r + 2'd1;
      end else begin
        win_nxt = asm_r;
        phase_nxt = '0;
        n = 2'd1;
        if ((w & EXP_MASK) != EXP_MASK) begin
          sum_a = sum_r + lo;
          sbl_nxt = sum_r;
          sum_nxt = sum_a + hi;
          ldw_nxt = w;
          if (fw_r != 16'hFFFF) fw_nxt = fw_r + 16'd1;
          fw_test = {1'b0, fw_nxt} + {16'd0, ~known_r};
          if (fw_test > limit) begin
            erc_nxt = erc_r + 32'd1;
            sync_nxt = SYNC_SEARCH; conf_nxt = '0;
            fw_nxt = '0; sum_nxt = '0; sbl_nxt = '0; ldw_nxt = '0;
            r0.kind = KIND_SYNC; r0.data_word = w; r0.status = ST_TOO_LONG;
          end else begin
            r0.kind = KIND_DATA; r0.data_word = w;
          end
        end else begin
          fw_nxt = '0; sum_nxt = '0; sbl_nxt = '0; ldw_nxt = '0;
          priority if (w == {HI_PLAIN, 16'd0}) begin
            okc_nxt = okc_r + 32'd1;
            r0.kind = KIND_END; r0.frame_type = FT_PLAIN; r0.word_count = fw_r;
            if (!known_r || fw_r != len_r) begin
              erc_nxt = erc_r + 32'd1;
              len_nxt = fw_r; known_nxt = 1'b1;
              sync_nxt = SYNC_SEARCH; conf_nxt = '0;
              r0.status = ST_LEN_CHG;
            end
          end else if (hi == HI_ALL) begin
            okc_nxt = okc_r + 32'd1;
            st_bit = lo != sum_r;
            if (st_bit) erc_nxt = erc_r + 32'd1;
            r0.kind = KIND_END; r0.frame_type = FT_ALL; r0.word_count = fw_r;
            r0.status = st_bit ? ST_SUM_ERR : ST_OK;
          end else if (hi == HI_DUMP) begin
            okc_nxt = okc_r + 32'd1;
            dsum = (fw_r != 16'd0) ? sbl_r : 16'd0;
            lv = (fw_r != 16'd0) ? ldw_r : 32'd0;
            st_bit = lo != dsum;
            if (st_bit) erc_nxt = erc_r + 32'd1;
            r0.kind = KIND_END; r0.frame_type = FT_DUMP;
            r0.word_count = (fw_r != 16'd0) ? fw_r - 16'd1 : 16'd0;
            r0.status = st_bit ? ST_SUM_ERR : ST_OK;
            priority if (lv[31] || lv < HALF_BITS) begin
              r0.dump_action = DA_NEW; pdk_nxt = 2'd0;
            end else if (lv > ONE_HALF_BITS) begin
              r0.dump_action = (pdk_r != 2'd2) ? DA_END_APP : DA_END_SOLO;
              pdk_nxt = 2'd2;
            end else begin
              r0.dump_action = DA_CONTINUE; pdk_nxt = 2'd1;
            end
          end else if (hi == HI_PRINT) begin
            okc_nxt = okc_r + 32'd1;
            r0.kind = KIND_PRINT; r1.kind = KIND_PRINT;
            priority if (w[7:0] != 8'd0 && w[15:8] != 8'd0) begin
              n = 2'd2; r0.text_char = w[7:0]; r1.text_char = w[15:8];
            end else if (w[7:0] != 8'd0) begin
              n = 2'd1; r0.text_char = w[7:0];
            end else if (w[15:8] != 8'd0) begin
              n = 2'd1; r0.text_char = w[15:8];
            end else begin
              n = 2'd0;
            end
          end else begin
            erc_nxt = erc_r + 32'd1;
            sync_nxt = SYNC_SEARCH; conf_nxt = '0;
            r0.kind = KIND_SYNC; r0.status = ST_UNKNOWN;
          end
        end
      end
    end else if (sync_r == SYNC_CONFIRM) begin
      conf_nxt = conf_r + 2'd1;
      if (match) begin
        n = 2'd1; r0.kind = KIND_SYNC;
        if (conf_nxt != 2'd0) begin
          conf_nxt = '0; erc_nxt = erc_r + 32'd1; r0.status = ST_MISALIGN;
        end else begin
          sync_nxt = SYNC_LOCKED; phase_nxt = '0; r0.status = ST_LOCKED;
        end
      end else begin
        win_nxt = {in_rx_byte, win_r[23:8]};
      end
    end else begin
      if (match) begin
        sync_nxt = SYNC_CONFIRM; conf_nxt = '0;
        n = 2'd1; r0.kind = KIND_SYNC; r0.status = ST_TAIL;
      end else begin
        win_nxt = {in_rx_byte, win_r[23:8]};
      end
    end
    r0.locked = sync_nxt == SYNC_LOCKED; r1.locked = r0.locked;
    r0.ok_frames = okc_nxt; r1.ok_frames = okc_nxt;
    r0.err_frames = erc_nxt; r1.err_frames = erc_nxt;
    r0.last = n == 2'd1; r1.last = 1'b1;
    job.nres = n; job.r0 = r0; job.r1 = (n == 2'd2) ? r1 : blank;
    job_valid = fire && n != 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_SEARCH; win_r <= WINDOW_RESET; conf_r <= '0; phase_r <= '0;
      asm_r <= '0; fw_r <= '0; len_r <= '0; known_r <= 1'b0; sum_r <= '0;
      sbl_r <= '0; ldw_r <= '0; pdk_r <= 2'd2; okc_r <= '0; erc_r <= '0;
    end else if (fire) begin
      sync_r <= sync_nxt; win_r <= win_nxt; conf_r <= conf_nxt; phase_r <= phase_nxt;
      asm_r <= asm_nxt; fw_r <= fw_nxt; len_r <= len_nxt; known_r <= known_nxt;
      sum_r <= sum_nxt; sbl_r <= sbl_nxt; ldw_r <= ldw_nxt; pdk_r <= pdk_nxt;
      okc_r <= okc_nxt; erc_r <= erc_nxt;
    end
  end

endmodule

>>> sv/ftd_queue.sv
// Two-entry queue of classified jobs between front and back.
`timescale 1ns / 1ps
module ftd_queue import ftd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_job    = mem_r[rp_r];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> sv/ftd_back.sv
// Back end: issues one or two results per job through an output register.
`timescale 1ns / 1ps
module ftd_back import ftd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  job_valid,
  output logic  job_ready,
  input  job_t  job,
  ftd_out_if.source out
);

  result_t res_r;
  logic    val_r;
  logic    second_r;
  logic    load;
  result_t pick;

  // Load a result when the register is empty or being drained.
  assign load = job_valid && (!val_r || out.ready);
  assign job_ready = load && (job.nres != 2'd2 || second_r);
  assign pick = second_r ? job.r1 : job.r0;

  always_ff @(posedge clk) begin
    if (load) res_r <= pick;
    if (!rst_n) begin
      val_r <= 1'b0; second_r <= 1'b0;
    end else begin
      if (load) val_r <= 1'b1;
      else if (out.ready) val_r <= 1'b0;
      if (load) second_r <= (job.nres == 2'd2) && !second_r;
    end
  end

  assign out.valid       = val_r;
  assign out.kind        = res_r.kind;
  assign out.data_word   = res_r.data_word;
  assign out.frame_type  = res_r.frame_type;
  assign out.status      = res_r.status;
  assign out.word_count  = res_r.word_count;
  assign out.dump_action = res_r.dump_action;
  assign out.text_char   = res_r.text_char;
  assign out.last        = res_r.last;
  assign out.locked      = res_r.locked;
  assign out.ok_frames   = res_r.ok_frames;
  assign out.err_frames  = res_r.err_frames;

endmodule

>>> sv/float_stream_tail_deframer_unit.sv
// Top level of the float stream tail deframer.
//  channel | dir | transaction
//  in_     | in  | one received byte with link state
//  out_    | out | one result (data, frame end, print char, sync event)
//  cfg_    | in  | frame length slack write
// One byte per cycle while the job queue is not full; a print tail with two characters
// makes the back end issue both, one after the other, through the single output register.
// Reset is synchronous on rst_n; slack returns to 1100.
// Output stalls fill the two-entry job queue and then drop in_ready.
`timescale 1ns / 1ps
module float_stream_tail_deframer_unit import ftd_pkg::*; (
  input logic clk,
  input logic rst_n,
  ftd_in_if.sink   in_ch,
  ftd_out_if.source out_ch,
  ftd_cfg_if.sink  cfg_ch
);

  logic [15:0] slack_r;
  logic        fj_valid, fj_ready, bj_valid, bj_ready;
  job_t        fj, bj;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) slack_r <= SLACK_RESET;
    else if (cfg_ch.valid) slack_r <= cfg_ch.data;
  end

  ftd_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_link_open(in_ch.link_open), .in_rx_byte(in_ch.rx_byte),
    .slack(slack_r),
    .job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
  );

  ftd_queue u_queue (
    .clk, .rst_n,
    .push_valid(fj_valid), .push_ready(fj_ready), .push_job(fj),
    .pop_valid(bj_valid), .pop_ready(bj_ready), .pop_job(bj)
  );

  ftd_back u_back (
    .clk, .rst_n,
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out(out_ch)
  );

endmodule
